### rtl/dskf_pkg.sv
// ----------------------------------------------------------------------------
// dskf_pkg
// Shared widths, register indexes, reset values and controller states for the
// two-axis scalar Kalman filter.
// ----------------------------------------------------------------------------
`default_nettype none

package dskf_pkg;

  localparam int AXES      = 2;
  localparam int AX_W      = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int FRAC_BITS = 30;

  localparam int POS_W  = 40;
  localparam int VAR_W  = 32;
  localparam int DEN_W  = VAR_W + 1;
  localparam int REM_W  = VAR_W + 2;
  localparam int G_W    = FRAC_BITS + 1;
  localparam int DIFF_W = POS_W + 1;
  localparam int MH_W   = DIFF_W - FRAC_BITS;
  localparam int HI_W   = MH_W + G_W;
  localparam int LO_W   = FRAC_BITS + G_W;
  localparam int VP_W   = G_W + VAR_W;
  localparam int CORR_W = HI_W + 1;
  localparam int NX_W   = CORR_W + 1;
  localparam int NP_W   = VP_W - FRAC_BITS + 1;
  localparam int CNT_W  = $clog2(G_W);

  localparam int IDX_W  = 3;
  localparam int CFG_W  = POS_W;
  localparam int DATA_W = 2 * POS_W;

  localparam logic [G_W-1:0]   GAIN_ONE = G_W'(1) << FRAC_BITS;
  localparam logic [CNT_W-1:0] DIV_TOP  = CNT_W'(G_W - 1);

  localparam logic [IDX_W-1:0] REG_PROC_NOISE = 3'd0;
  localparam logic [IDX_W-1:0] REG_MEAS_NOISE = 3'd1;
  localparam logic [IDX_W-1:0] REG_INIT_POS_A = 3'd2;
  localparam logic [IDX_W-1:0] REG_INIT_POS_B = 3'd3;
  localparam logic [IDX_W-1:0] REG_INIT_VAR   = 3'd4;

  localparam logic [VAR_W-1:0]        RST_PROC_NOISE = 32'd107374;
  localparam logic [VAR_W-1:0]        RST_MEAS_NOISE = 32'd10737418;
  localparam logic signed [POS_W-1:0] RST_INIT_POS   = '0;
  localparam logic [VAR_W-1:0]        RST_INIT_VAR   = 32'd1073741824;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_GAIN,
    ST_MUL,
    ST_SUM,
    ST_UPD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic            take_in;
    logic            load;
    logic            div_step;
    logic            gain_en;
    logic            mul_en;
    logic            sum_en;
    logic            upd_en;
    logic            out_load;
    logic [AX_W-1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

### rtl/dskf_ctrl.sv
// ----------------------------------------------------------------------------
// dskf_ctrl
// Sequencer: steps each axis through load, divide, gain, multiply, sum and
// update, then hands both estimates to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dskf_ctrl (
  input  wire                logic             clk,
  input  wire                logic             rst,
  input  wire                logic             in_valid,
  output logic                                 in_ready,
  input  wire                dskf_pkg::status_t status,
  output dskf_pkg::cmd_t                       cmd
);

  dskf_pkg::state_t                state, state_next;
  logic [dskf_pkg::AX_W-1:0]       axis, axis_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dskf_pkg::ST_IDLE;
      axis  <= '0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
    end
  end

  always_comb begin
    state_next = state;
    axis_next  = axis;
    cmd        = '0;
    cmd.axis   = axis;
    in_ready   = 1'b0;
    unique case (state)
      dskf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_in = 1'b1;
          axis_next   = '0;
          state_next  = dskf_pkg::ST_LOAD;
        end
      end
      dskf_pkg::ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = dskf_pkg::ST_DIV;
      end
      dskf_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = dskf_pkg::ST_GAIN;
        end
      end
      dskf_pkg::ST_GAIN: begin
        cmd.gain_en = 1'b1;
        state_next  = dskf_pkg::ST_MUL;
      end
      dskf_pkg::ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = dskf_pkg::ST_SUM;
      end
      dskf_pkg::ST_SUM: begin
        cmd.sum_en = 1'b1;
        state_next = dskf_pkg::ST_UPD;
      end
      dskf_pkg::ST_UPD: begin
        cmd.upd_en = 1'b1;
        if (axis == dskf_pkg::AX_W'(dskf_pkg::AXES - 1)) begin
          state_next = dskf_pkg::ST_OUT;
        end else begin
          axis_next  = axis + 1'b1;
          state_next = dskf_pkg::ST_LOAD;
        end
      end
      dskf_pkg::ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = dskf_pkg::ST_IDLE;
        end
      end
      default: state_next = dskf_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### rtl/dskf_datapath.sv
// ----------------------------------------------------------------------------
// dskf_datapath
// Configuration registers, per-axis filter state, a bit-serial gain divider,
// the correction and variance multipliers, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dskf_datapath (
  input  wire  logic                               clk,
  input  wire  logic                               rst,
  input  wire  dskf_pkg::cmd_t                     cmd,
  output dskf_pkg::status_t                        status,
  input  wire  logic                               cfg_we,
  input  wire  logic [dskf_pkg::IDX_W-1:0]         cfg_index,
  input  wire  logic [dskf_pkg::CFG_W-1:0]         cfg_data,
  input  wire  logic [dskf_pkg::DATA_W-1:0]        in_data,
  output logic                                     out_valid,
  input  wire  logic                               out_ready,
  output logic [dskf_pkg::DATA_W-1:0]              out_data
);

  localparam int POS_W = dskf_pkg::POS_W;
  localparam int VAR_W = dskf_pkg::VAR_W;
  localparam int FRAC  = dskf_pkg::FRAC_BITS;

  logic [VAR_W-1:0]              proc_noise, meas_noise, init_var;
  logic signed [POS_W-1:0]       init_pos_a, init_pos_b;
  logic [VAR_W-1:0]              proc_noise_next, meas_noise_next, init_var_next;
  logic signed [POS_W-1:0]       init_pos_a_next, init_pos_b_next;
  logic                          reload;

  logic signed [POS_W-1:0]       estimate [dskf_pkg::AXES];
  logic [VAR_W-1:0]              err_var  [dskf_pkg::AXES];
  logic signed [POS_W-1:0]       meas     [dskf_pkg::AXES];

  logic signed [POS_W-1:0]       x_cur, m_cur;
  logic [VAR_W-1:0]              p_cur;

  logic [dskf_pkg::DEN_W-1:0]    den;
  logic                          den_zero;
  logic signed [dskf_pkg::DIFF_W-1:0] diff;
  logic [dskf_pkg::REM_W-1:0]    rem, rem_sh, rem_sub;
  logic                          rem_ge;
  logic [dskf_pkg::G_W-1:0]      quot, gain;
  logic [dskf_pkg::CNT_W-1:0]    cnt;
  logic                          first_bit;

  logic [dskf_pkg::DIFF_W-1:0]   mag;
  logic                          neg;
  logic [dskf_pkg::HI_W-1:0]     prod_hi;
  logic [dskf_pkg::LO_W-1:0]     prod_lo;
  logic [dskf_pkg::VP_W-1:0]     prod_var;
  logic [dskf_pkg::CORR_W-1:0]   corr;
  logic [dskf_pkg::NP_W-1:0]     np_sum;
  logic [VAR_W-1:0]              np_sat;
  logic signed [dskf_pkg::NX_W-1:0] nx;
  logic signed [POS_W-1:0]       nx_sat;

  // configuration decode
  always_comb begin
    proc_noise_next = proc_noise;
    meas_noise_next = meas_noise;
    init_pos_a_next = init_pos_a;
    init_pos_b_next = init_pos_b;
    init_var_next   = init_var;
    reload          = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        dskf_pkg::REG_PROC_NOISE: begin
          proc_noise_next = cfg_data[VAR_W-1:0];
          reload          = 1'b1;
        end
        dskf_pkg::REG_MEAS_NOISE: begin
          meas_noise_next = cfg_data[VAR_W-1:0];
          reload          = 1'b1;
        end
        dskf_pkg::REG_INIT_POS_A: begin
          init_pos_a_next = cfg_data;
          reload          = 1'b1;
        end
        dskf_pkg::REG_INIT_POS_B: begin
          init_pos_b_next = cfg_data;
          reload          = 1'b1;
        end
        dskf_pkg::REG_INIT_VAR: begin
          init_var_next = cfg_data[VAR_W-1:0];
          reload        = 1'b1;
        end
        default: reload = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      proc_noise <= dskf_pkg::RST_PROC_NOISE;
      meas_noise <= dskf_pkg::RST_MEAS_NOISE;
      init_pos_a <= dskf_pkg::RST_INIT_POS;
      init_pos_b <= dskf_pkg::RST_INIT_POS;
      init_var   <= dskf_pkg::RST_INIT_VAR;
    end else begin
      proc_noise <= proc_noise_next;
      meas_noise <= meas_noise_next;
      init_pos_a <= init_pos_a_next;
      init_pos_b <= init_pos_b_next;
      init_var   <= init_var_next;
    end
  end

  // filter state: reset or reload from the initial values, else update
  always_ff @(posedge clk) begin
    for (int i = 0; i < dskf_pkg::AXES; i++) begin
      if (rst) begin
        estimate[i] <= dskf_pkg::RST_INIT_POS;
        err_var[i]  <= dskf_pkg::RST_INIT_VAR;
      end else if (reload) begin
        estimate[i] <= (i == 0) ? init_pos_a_next : init_pos_b_next;
        err_var[i]  <= init_var_next;
      end else if (cmd.upd_en && cmd.axis == dskf_pkg::AX_W'(i)) begin
        estimate[i] <= nx_sat;
        err_var[i]  <= np_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      for (int i = 0; i < dskf_pkg::AXES; i++) begin
        meas[i] <= in_data[i*POS_W +: POS_W];
      end
    end
  end

  assign x_cur = estimate[cmd.axis];
  assign p_cur = err_var[cmd.axis];
  assign m_cur = meas[cmd.axis];

  // gain divider, one quotient bit per cycle
  assign rem_sh  = {rem[dskf_pkg::REM_W-2:0], first_bit & p_cur[0]};
  assign rem_ge  = rem_sh >= {1'b0, den};
  assign rem_sub = rem_sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      den       <= {1'b0, p_cur} + {1'b0, meas_noise};
      diff      <= {m_cur[POS_W-1], m_cur} - {x_cur[POS_W-1], x_cur};
      rem       <= {2'b00, 1'b0, p_cur[VAR_W-1:1]};
      quot      <= '0;
      cnt       <= dskf_pkg::DIV_TOP;
      first_bit <= 1'b1;
    end else if (cmd.div_step) begin
      rem       <= rem_ge ? rem_sub : rem_sh;
      quot      <= {quot[dskf_pkg::G_W-2:0], rem_ge};
      cnt       <= cnt - 1'b1;
      first_bit <= 1'b0;
    end
  end

  assign den_zero        = (den == '0);
  assign status.div_last = (cnt == '0);

  always_ff @(posedge clk) begin
    if (cmd.gain_en) begin
      gain <= den_zero ? '0 : quot;
      neg  <= diff[dskf_pkg::DIFF_W-1];
      mag  <= diff[dskf_pkg::DIFF_W-1] ? dskf_pkg::DIFF_W'(-diff) : dskf_pkg::DIFF_W'(diff);
    end
    if (cmd.mul_en) begin
      prod_hi  <= mag[dskf_pkg::DIFF_W-1:FRAC] * gain;
      prod_lo  <= mag[FRAC-1:0] * gain;
      prod_var <= (dskf_pkg::GAIN_ONE - gain) * p_cur;
    end
    if (cmd.sum_en) begin
      corr   <= {1'b0, prod_hi} + dskf_pkg::CORR_W'(prod_lo[dskf_pkg::LO_W-1:FRAC]);
      np_sat <= (np_sum[dskf_pkg::NP_W-1:VAR_W] != '0) ? '1 : np_sum[VAR_W-1:0];
    end
  end

  assign np_sum = {1'b0, prod_var[dskf_pkg::VP_W-1:FRAC]} + dskf_pkg::NP_W'(proc_noise);

  assign nx = neg ? dskf_pkg::NX_W'(x_cur) - $signed({1'b0, corr})
                  : dskf_pkg::NX_W'(x_cur) + $signed({1'b0, corr});

  always_comb begin
    if (nx[dskf_pkg::NX_W-1:POS_W-1] == '0 || nx[dskf_pkg::NX_W-1:POS_W-1] == '1) begin
      nx_sat = nx[POS_W-1:0];
    end else if (nx[dskf_pkg::NX_W-1]) begin
      nx_sat = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      nx_sat = {1'b0, {(POS_W-1){1'b1}}};
    end
  end

  // output register
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int i = 0; i < dskf_pkg::AXES; i++) begin
        out_data[i*POS_W +: POS_W] <= estimate[i];
      end
    end
  end

endmodule

`default_nettype wire

### rtl/dual_scalar_kalman_filter.sv
// ----------------------------------------------------------------------------
// dual_scalar_kalman_filter
// Two independent scalar Kalman filters on a two-axis position stream.
// ----------------------------------------------------------------------------
// Each transaction on s_* carries one measurement per axis and yields one
// transaction on m_* with both new estimates (signed Q9.30, saturated). The
// axes are processed one after the other through a shared restoring divider
// that forms one gain bit per cycle. Each item is first accepted, then each
// axis in turn is loaded, divided, and taken through gain, multiply, sum and
// update, and then both estimates are loaded into the output register; a new
// item is accepted only after that. s_tready is high only while the block is
// idle; a finished result waits in the output register, and the next one
// holds until that register drains. Any write on the cfg_* port to a known
// index reloads both estimates and variances from the initial-value
// registers; write it only while the block is idle.
`default_nettype none

module dual_scalar_kalman_filter (
  input  wire  logic                             clk,
  input  wire  logic                             rst,
  input  wire  logic                             s_tvalid,
  output logic                                   s_tready,
  input  wire  logic [dskf_pkg::DATA_W-1:0]      s_tdata,   // meas_a, meas_b
  output logic                                   m_tvalid,
  input  wire  logic                             m_tready,
  output logic [dskf_pkg::DATA_W-1:0]            m_tdata,   // est_a, est_b
  input  wire  logic                             cfg_valid,
  output logic                                   cfg_ready,
  input  wire  logic [dskf_pkg::IDX_W-1:0]       cfg_index,
  input  wire  logic [dskf_pkg::CFG_W-1:0]       cfg_data
);

  dskf_pkg::cmd_t    cmd;
  dskf_pkg::status_t status;

  assign cfg_ready = 1'b1;

  dskf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  dskf_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

`default_nettype wire
